FILE: rtl/core/rbmc_pkg.sv
// ----------------------------------------------------------------------------
// rbmc_pkg
// Shared types, constants and lookup tables of the RGBA blend-mode compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package rbmc_pkg;

  localparam int CH_W       = 8;
  localparam int U_W        = 17;
  localparam int Q_W        = 20;
  localparam int ONE_Q      = 65536;
  localparam int HALF_Q     = 32768;
  localparam int QUART_Q    = 16384;
  localparam int NUM_W      = 44;
  localparam int DEN_W      = 34;
  localparam int QUO_W      = 10;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = QUO_W / DIV_STEPS;
  localparam int PIPE_LAT   = 8 + DIV_STAGES;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [26:0] RECIP_255 = 27'd67372037;

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic [U_W-1:0]        uq_t;
  typedef logic [CH_W-1:0]       chan_t;

  typedef enum logic [2:0] {
    MODE_NORMAL,
    MODE_MULTIPLY,
    MODE_SCREEN,
    MODE_OVERLAY,
    MODE_ADD,
    MODE_SOFT_LIGHT
  } mode_t;

  localparam logic REG_BLEND_MODE = 1'b0;
  localparam logic REG_OPACITY    = 1'b1;

  typedef uq_t uq_lut_t [256];
  typedef q_t  q_lut_t  [256];

  function automatic longint mulq_c(longint a, longint b);
    longint p;
    p = a * b;
    if (p >= 0) begin
      return (p + HALF_Q) / ONE_Q;
    end
    return -((-p + HALF_Q) / ONE_Q);
  endfunction

  function automatic longint sqrt_c(longint b);
    longint x;
    longint r;
    longint bt;
    longint rem;
    bit     run;
    x   = b * ONE_Q;
    r   = 0;
    bt  = longint'(1) << 34;
    rem = x;
    run = 1'b0;
    for (int i = 0; i < 18; i++) begin
      if (bt != 0) begin
        if (run || bt <= x) begin
          run = 1'b1;
          if (rem >= r + bt) begin
            rem = rem - (r + bt);
            r   = (r >> 1) + bt;
          end else begin
            r = r >> 1;
          end
        end
        bt = bt >> 2;
      end
    end
    if (x - r * r > r) begin
      r = r + 1;
    end
    return r;
  endfunction

  function automatic uq_lut_t build_to_q();
    uq_lut_t t;
    for (int c = 0; c < 256; c++) begin
      t[c] = uq_t'((longint'(c) * 131072 + 255) / 510);
    end
    return t;
  endfunction

  function automatic q_lut_t build_soft_d();
    q_lut_t t;
    longint b;
    longint d;
    for (int c = 0; c < 256; c++) begin
      b = (longint'(c) * 131072 + 255) / 510;
      if (b <= QUART_Q) begin
        d = mulq_c(16 * b - 12 * longint'(ONE_Q), b) + 4 * longint'(ONE_Q);
        d = mulq_c(d, b);
      end else begin
        d = sqrt_c(b);
      end
      t[c] = q_t'(d);
    end
    return t;
  endfunction

  localparam uq_lut_t TO_Q_LUT   = build_to_q();
  localparam q_lut_t  SOFT_D_LUT = build_soft_d();

  function automatic q_t mulq(q_t a, q_t b);
    logic signed [2*Q_W-1:0] p;
    logic signed [2*Q_W-1:0] r;
    p = a * b;
    if (p >= 0) begin
      r = (p + (2*Q_W)'(HALF_Q)) >>> 16;
    end else begin
      r = -((-p + (2*Q_W)'(HALF_Q)) >>> 16);
    end
    return q_t'(r);
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/rbmc_mix.sv
// ----------------------------------------------------------------------------
// rbmc_mix
// Three-stage blend-mode mixer for one colour channel.
// ----------------------------------------------------------------------------
`default_nettype none

module rbmc_mix (
  input  wire logic            clk,
  input  wire rbmc_pkg::uq_t   s_i,
  input  wire rbmc_pkg::uq_t   b_i,
  input  wire rbmc_pkg::q_t    d_i,
  input  wire rbmc_pkg::mode_t mode_i,
  input  wire logic            en_i,
  output rbmc_pkg::q_t         mix_o,
  output rbmc_pkg::uq_t        base_o
);
  import rbmc_pkg::*;

  q_t    sq;
  q_t    bq;
  q_t    one;
  q_t    s_a_r, b_a_r, mbs_a_r, mov_a_r, msl_a_r, mt_a_r;
  mode_t mode_a_r;
  logic  en_a_r;
  q_t    s_b_r, b_b_r, mbs_b_r, mov_b_r, msl_b_r, mt_b_r;
  mode_t mode_b_r;
  logic  en_b_r;
  q_t    mix_nxt, mix_r;
  uq_t   base_r;

  assign sq  = q_t'(s_i);
  assign bq  = q_t'(b_i);
  assign one = q_t'(ONE_Q);

  always_ff @(posedge clk) begin
    s_a_r    <= sq;
    b_a_r    <= bq;
    mbs_a_r  <= mulq(bq, sq);
    mov_a_r  <= mulq(one - bq, one - sq);
    msl_a_r  <= mulq(one - (sq <<< 1), bq);
    mt_a_r   <= mulq((sq <<< 1) - one, d_i - bq);
    mode_a_r <= mode_i;
    en_a_r   <= en_i;
  end

  always_ff @(posedge clk) begin
    s_b_r    <= s_a_r;
    b_b_r    <= b_a_r;
    mbs_b_r  <= mbs_a_r;
    mov_b_r  <= mov_a_r;
    msl_b_r  <= mulq(msl_a_r, one - b_a_r);
    mt_b_r   <= mt_a_r;
    mode_b_r <= mode_a_r;
    en_b_r   <= en_a_r;
  end

  always_comb begin
    mix_nxt = s_b_r;
    if (en_b_r) begin
      case (mode_b_r)
        MODE_MULTIPLY: mix_nxt = mbs_b_r;
        MODE_SCREEN:   mix_nxt = b_b_r + s_b_r - mbs_b_r;
        MODE_OVERLAY: begin
          if (b_b_r <= q_t'(HALF_Q)) begin
            mix_nxt = mbs_b_r <<< 1;
          end else begin
            mix_nxt = one - (mov_b_r <<< 1);
          end
        end
        MODE_ADD:      mix_nxt = b_b_r + s_b_r;
        MODE_SOFT_LIGHT: begin
          if (s_b_r <= q_t'(HALF_Q)) begin
            mix_nxt = b_b_r - msl_b_r;
          end else begin
            mix_nxt = b_b_r + mt_b_r;
          end
        end
        default:       mix_nxt = s_b_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mix_r  <= mix_nxt;
    base_r <= uq_t'(b_b_r);
  end

  assign mix_o  = mix_r;
  assign base_o = base_r;

endmodule

`default_nettype wire

FILE: rtl/core/rbmc_div.sv
// ----------------------------------------------------------------------------
// rbmc_div
// Pipelined restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module rbmc_div (
  input  wire logic                        clk,
  input  wire logic [rbmc_pkg::NUM_W-1:0]  num_i,
  input  wire logic [rbmc_pkg::DEN_W-1:0]  den_i,
  output logic      [rbmc_pkg::QUO_W-1:0]  quo_o
);
  import rbmc_pkg::*;

  logic [NUM_W-1:0] rem_r [DIV_STAGES-1];
  logic [DEN_W-1:0] den_r [DIV_STAGES-1];
  logic [QUO_W-1:0] quo_r [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
    logic [NUM_W-1:0] rem_in;
    logic [NUM_W-1:0] rem_nxt;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic [QUO_W-1:0] quo_nxt;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign den_in = den_r[g-1];
      assign quo_in = quo_r[g-1];
    end

    always_comb begin
      logic [NUM_W-1:0] trial;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = NUM_W'(den_in) << (QUO_W - 1 - g * DIV_STEPS - k);
        if (rem_nxt >= trial) begin
          rem_nxt = rem_nxt - trial;
          quo_nxt[QUO_W - 1 - g * DIV_STEPS - k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      quo_r[g] <= quo_nxt;
    end

    if (g < DIV_STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[g] <= rem_nxt;
        den_r[g] <= den_in;
      end
    end
  end

  assign quo_o = quo_r[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/rgba_blend_mode_compositor_core.sv
// ----------------------------------------------------------------------------
// rgba_blend_mode_compositor_core
// Straight-alpha over compositing of a top pixel onto a base pixel with
// separable blend modes and a global layer opacity.
// ----------------------------------------------------------------------------
// A pixel request is taken at a clock edge with start high and busy low.
// busy is always low, so a new pixel may be offered in every cycle and the
// block sustains one pixel per clock.
// Each result appears on out_red, out_green, out_blue and out_alpha for one
// cycle with out_valid high.
// The pipeline holds one input stage, three mixer stages (the opacity
// scaling by a reciprocal multiply runs beside the first of them), two
// product and sum stages, one scaling stage, five divider stages for the
// division by the output alpha, and the output register.
// The receiver cannot stall; results are not held.
// The APB port holds blend_mode at address 0 and global_opacity at address 4.
// The user writes registers only while no request is in flight (unchecked).
// Reset clears the valid bits and restores normal mode and full opacity.
// ----------------------------------------------------------------------------
`default_nettype none

module rgba_blend_mode_compositor_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [7:0]                   in_top_red,
  input  wire logic [7:0]                   in_top_green,
  input  wire logic [7:0]                   in_top_blue,
  input  wire logic [7:0]                   in_top_alpha,
  input  wire logic [7:0]                   in_base_red,
  input  wire logic [7:0]                   in_base_green,
  input  wire logic [7:0]                   in_base_blue,
  input  wire logic [7:0]                   in_base_alpha,
  output logic                              out_valid,
  output logic [7:0]                        out_red,
  output logic [7:0]                        out_green,
  output logic [7:0]                        out_blue,
  output logic [7:0]                        out_alpha,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [rbmc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rbmc_pkg::DATA_W-1:0]  pwdata,
  output logic      [rbmc_pkg::DATA_W-1:0]  prdata,
  output logic                              pready
);
  import rbmc_pkg::*;

  typedef chan_t [3:0] pix_t;

  typedef struct packed {
    logic  bypass;
    pix_t  base;
    chan_t alpha;
  } side_t;

  logic [2:0]          mode_r;
  logic [8:0]          opacity_r;
  logic                wr_en;
  logic                accept;
  logic [PIPE_LAT-2:0] vld_r;
  logic [8:0]          op_sat;
  chan_t               top_c  [3];
  chan_t               base_c [3];

  // Stage 1.
  logic [15:0] p1_r;
  uq_t         tq1_r [3];
  uq_t         bq1_r [3];
  q_t          dq1_r [3];
  uq_t         ba1_r;
  mode_t       mode1_r;
  logic        en1_r;
  pix_t        base1_r;

  // Alpha path, stages 2 to 7.
  logic [51:0] sa_prod;
  uq_t         sa2_r, sa3_r, sa4_r;
  uq_t         ba2_r;
  logic [34:0] keep_p;
  uq_t         keep3_r, keep4_r;
  uq_t         oa4_r, oa5_r, oa6_r;
  logic [25:0] alpha_p;
  logic        bypass_r [2:7];
  pix_t        base_r   [2:7];
  side_t       side7;
  side_t       side_r   [DIV_STAGES];

  // Colour channels.
  q_t                      mix4    [3];
  uq_t                     b4      [3];
  logic signed [37:0]      pm5_r   [3];
  logic [33:0]             pb5_r   [3];
  logic signed [38:0]      num6_r  [3];
  logic [NUM_W-1:0]        n7_r    [3];
  logic [DEN_W-1:0]        d7_r;
  logic [QUO_W-1:0]        quo     [3];
  chan_t                   rgb_nxt [3];

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= 3'(MODE_NORMAL);
      opacity_r <= 9'd256;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_BLEND_MODE: mode_r    <= pwdata[2:0];
        REG_OPACITY:    opacity_r <= pwdata[8:0];
        default:        mode_r    <= mode_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLEND_MODE: prdata = DATA_W'(mode_r);
      REG_OPACITY:    prdata = DATA_W'(opacity_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[PIPE_LAT-3:0], accept};
    end
  end

  assign op_sat    = (opacity_r > 9'd256) ? 9'd256 : opacity_r;
  assign top_c[0]  = in_top_red;
  assign top_c[1]  = in_top_green;
  assign top_c[2]  = in_top_blue;
  assign base_c[0] = in_base_red;
  assign base_c[1] = in_base_green;
  assign base_c[2] = in_base_blue;

  always_ff @(posedge clk) begin
    p1_r    <= 16'(in_top_alpha) * 16'(op_sat);
    ba1_r   <= TO_Q_LUT[in_base_alpha];
    mode1_r <= mode_t'(mode_r);
    en1_r   <= (in_base_alpha != 8'd0);
    base1_r <= {in_base_alpha, in_base_blue, in_base_green, in_base_red};
    for (int c = 0; c < 3; c++) begin
      tq1_r[c] <= TO_Q_LUT[top_c[c]];
      bq1_r[c] <= TO_Q_LUT[base_c[c]];
      dq1_r[c] <= SOFT_D_LUT[base_c[c]];
    end
  end

  // Effective top alpha: round(p * 256 / 255) by a reciprocal multiply.
  assign sa_prod = 52'({p1_r, 8'h7f}) * 52'(RECIP_255);
  assign keep_p  = 35'(ba2_r) * 35'(uq_t'(ONE_Q) - sa2_r) + 35'(HALF_Q);
  assign alpha_p = 26'(d7_r[33:17]) * 26'd255 + 26'(HALF_Q);

  always_ff @(posedge clk) begin
    sa2_r       <= sa_prod[50:34];
    ba2_r       <= ba1_r;
    bypass_r[2] <= (p1_r == 16'd0);
    base_r[2]   <= base1_r;
    keep3_r     <= keep_p[32:16];
    sa3_r       <= sa2_r;
    sa4_r       <= sa3_r;
    keep4_r     <= keep3_r;
    oa4_r       <= sa3_r + keep3_r;
    oa5_r       <= oa4_r;
    oa6_r       <= oa5_r;
    d7_r        <= {oa6_r, 17'd0};
    for (int k = 3; k <= 7; k++) begin
      bypass_r[k] <= bypass_r[k-1];
      base_r[k]   <= base_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= side7;
    for (int k = 1; k < DIV_STAGES; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  assign side7 = '{bypass: bypass_r[7], base: base_r[7], alpha: alpha_p[23:16]};

  for (genvar c = 0; c < 3; c++) begin : g_chan
    rbmc_mix u_mix (
      .clk    (clk),
      .s_i    (tq1_r[c]),
      .b_i    (bq1_r[c]),
      .d_i    (dq1_r[c]),
      .mode_i (mode1_r),
      .en_i   (en1_r),
      .mix_o  (mix4[c]),
      .base_o (b4[c])
    );

    always_ff @(posedge clk) begin
      pm5_r[c]  <= 38'(mix4[c]) * 38'($signed({1'b0, sa4_r}));
      pb5_r[c]  <= 34'(b4[c]) * 34'(keep4_r);
      num6_r[c] <= 39'(pm5_r[c]) + 39'($signed({1'b0, pb5_r[c]}));
      if (num6_r[c] > 39'sd0) begin
        n7_r[c] <= NUM_W'(num6_r[c][33:0]) * NUM_W'(510) + NUM_W'({oa6_r, 16'd0});
      end else begin
        n7_r[c] <= '0;
      end
    end

    rbmc_div u_div (
      .clk   (clk),
      .num_i (n7_r[c]),
      .den_i (d7_r),
      .quo_o (quo[c])
    );

    always_comb begin
      if (side_r[DIV_STAGES-1].bypass) begin
        rgb_nxt[c] = side_r[DIV_STAGES-1].base[c];
      end else if (quo[c] > QUO_W'(255)) begin
        rgb_nxt[c] = 8'd255;
      end else begin
        rgb_nxt[c] = quo[c][7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld_r[PIPE_LAT-2];
    end
  end

  always_ff @(posedge clk) begin
    out_red   <= rgb_nxt[0];
    out_green <= rgb_nxt[1];
    out_blue  <= rgb_nxt[2];
    out_alpha <= side_r[DIV_STAGES-1].bypass ? side_r[DIV_STAGES-1].base[3]
                                            : side_r[DIV_STAGES-1].alpha;
  end

endmodule

`default_nettype wire

FILE: rtl/core/rbmc_checker.sv
// ----------------------------------------------------------------------------
// rbmc_checker
// Port-level checks of request-to-result timing and base pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module rbmc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic [7:0] in_top_alpha,
  input wire logic [7:0] in_base_red,
  input wire logic [7:0] in_base_alpha,
  input wire logic       out_valid,
  input wire logic [7:0] out_red,
  input wire logic [7:0] out_alpha
);

  property p_result_follows;
    @(posedge clk) disable iff (!rst_n)
      (start && !busy) |-> ##13 out_valid;
  endproperty

  property p_no_spurious;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> $past(start && !busy && rst_n, 13);
  endproperty

  property p_passthrough;
    @(posedge clk) disable iff (!rst_n)
      (start && !busy && in_top_alpha == 8'd0) |-> ##13
        (out_red == $past(in_base_red, 13) && out_alpha == $past(in_base_alpha, 13));
  endproperty

  a_result_follows: assert property (p_result_follows)
    else $error("request without result");
  a_no_spurious: assert property (p_no_spurious)
    else $error("result without request");
  a_passthrough: assert property (p_passthrough)
    else $error("transparent top did not pass the base through");

endmodule

bind rgba_blend_mode_compositor_core rbmc_checker u_rbmc_checker (.*);

`default_nettype wire
